/* hdl/sce_pkg.sv */
// shared constants, types and helpers of the sensor coverage evaluator
package sce_pkg;

    // storage sizes
    localparam int MAX_NODES   = 32;
    localparam int MAX_REGIONS = 64;
    localparam int AREA_BITS   = 24;

    // derived widths
    localparam int NODE_IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NODE_NUM_W = $clog2(MAX_NODES + 1);
    localparam int REG_IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int REG_NUM_W  = $clog2(MAX_REGIONS + 1);
    localparam int CNT_W      = (NODE_NUM_W > REG_NUM_W) ? NODE_NUM_W : REG_NUM_W;

    // fixed field widths
    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 6;
    localparam int AREA_W     = 24;
    localparam int MASK_W     = 32;
    localparam int COV_W      = 32;
    localparam int NODE_CFG_W = 6;
    localparam int REG_CFG_W  = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // running sums keep headroom above the 32-bit result range
    localparam int ACC_W = 34;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_NODE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_REGION = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT        = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EVAL        = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT = 1'd1;

    // controller to datapath commands
    typedef struct packed {
        logic             accept;
        logic             node_rd;
        logic             region_rd;
        logic             clamp;
        logic             finish;
        logic [CNT_W-1:0] addr;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [NODE_NUM_W-1:0] node_num;
        logic [REG_NUM_W-1:0]  region_num;
        logic                  out_blocked;
    } t_dp_sts;

    // saturate a running sum to the signed 32-bit range
    function automatic logic signed [COV_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = ACC_W'(-64'sd2147483648);
        if (v > hi) begin
            return COV_W'(hi);
        end else if (v < lo) begin
            return COV_W'(lo);
        end else begin
            return COV_W'(v);
        end
    endfunction

endpackage

/* hdl/sensor_coverage_evaluator_core.sv */
// Top level of the sensor coverage evaluator.
// Input channel (i_in_valid / o_in_ready) carries one command beat: load a
// node area, load a region (area and owner mask), start a session with an
// alive mask, or evaluate with sleep and alive masks. Only evaluate returns a
// beat on the output channel (o_out_valid / i_out_ready): partial coverage,
// session total and exclusive area, signed integers.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes node_count
// (index 0) and region_count (index 1); it is always ready. The user must
// write it only while no command is in flight; the block does not enforce this.
// Loads free the input channel in the next cycle. Init and evaluate walk the
// node store one entry per cycle, drain, clamp the partial sum, then walk the
// region store one entry per cycle (counts capped at 32 and 64), drain and
// finish; the input channel stays busy until the finish, and the single read
// port of each store sets the pace of the walks. One command is worked on
// at a time.
// The result sits in an output register; while the receiver stalls the next
// command is still accepted, and an evaluate that finishes meanwhile holds
// in its last step until the register is free.
// Reset clears node areas to zero, the session total to zero, node_count to
// 32 and region_count to 0; region entries hold nothing until loaded.
module sensor_coverage_evaluator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [sce_pkg::CMD_W-1:0]            i_command,
    input  logic [sce_pkg::INDEX_W-1:0]          i_index,
    input  logic [sce_pkg::AREA_W-1:0]           i_area,
    input  logic [sce_pkg::MASK_W-1:0]           i_owner_mask,
    input  logic [sce_pkg::MASK_W-1:0]           i_sleep_mask,
    input  logic [sce_pkg::MASK_W-1:0]           i_alive_mask,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [sce_pkg::COV_W-1:0]     o_awake_cov,
    output logic signed [sce_pkg::COV_W-1:0]     o_session_cov,
    output logic signed [sce_pkg::COV_W-1:0]     o_solo_area,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sce_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sce_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    sce_pkg::t_dp_cmd s_cmd;
    sce_pkg::t_dp_sts s_sts;

    assign o_cfg_ready = 1'b1;

    // sequencing
    sce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_sts      (s_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (s_cmd)
    );

    // stores and arithmetic
    sce_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .o_sts          (s_sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_index        (i_index),
        .i_area         (i_area),
        .i_owner_mask   (i_owner_mask),
        .i_sleep_mask   (i_sleep_mask),
        .i_alive_mask   (i_alive_mask),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_awake_cov    (o_awake_cov),
        .o_session_cov  (o_session_cov),
        .o_solo_area    (o_solo_area)
    );

`ifndef SYNTHESIS
    // a load beat frees the input channel again in the next cycle
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_command == sce_pkg::CMD_LOAD_NODE ||
                                      i_command == sce_pkg::CMD_LOAD_REGION))
        |=> o_in_ready)
        else $error("load beat did not free the input channel");

    // init and evaluate keep the input channel busy while walking
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_command == sce_pkg::CMD_INIT ||
                                      i_command == sce_pkg::CMD_EVAL))
        |=> !o_in_ready)
        else $error("input accepted during a store walk");

    // a result only appears after the controller finishes an item
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(s_cmd.finish))
        else $error("result beat without a finished evaluate");

    // the session total never goes negative
    a_total_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_session_cov[sce_pkg::COV_W-1])
        else $error("negative session total");
`endif

endmodule

/* hdl/sce_ctrl.sv */
// controller: sequences the node walk, clamp, region walk and result hand-off
module sce_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic [sce_pkg::CMD_W-1:0]          i_command,
    input  sce_pkg::t_dp_sts                   i_sts,
    output logic                               o_in_ready,
    output sce_pkg::t_dp_cmd                   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_NODE   = 3'd1;
    localparam logic [2:0] S_NDRAIN = 3'd2;
    localparam logic [2:0] S_CLAMP  = 3'd3;
    localparam logic [2:0] S_REG    = 3'd4;
    localparam logic [2:0] S_RDRAIN = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]                r_state, n_state;
    logic [sce_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_is_eval, n_is_eval;
    logic [sce_pkg::CNT_W-1:0] cnt_inc;

    assign cnt_inc    = r_cnt + 1'b1;
    assign o_in_ready = (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_is_eval    = r_is_eval;
        o_cmd        = '0;
        o_cmd.addr   = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && (i_command == sce_pkg::CMD_INIT ||
                                   i_command == sce_pkg::CMD_EVAL)) begin
                    n_is_eval = (i_command == sce_pkg::CMD_EVAL);
                    n_cnt     = '0;
                    n_state   = (i_sts.node_num == '0) ? S_NDRAIN : S_NODE;
                end
            end
            S_NODE: begin
                o_cmd.node_rd = 1'b1;
                n_cnt         = cnt_inc;
                if (cnt_inc == sce_pkg::CNT_W'(i_sts.node_num)) begin
                    n_state = S_NDRAIN;
                end
            end
            S_NDRAIN: begin
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_cnt       = '0;
                n_state     = (i_sts.region_num == '0) ? S_RDRAIN : S_REG;
            end
            S_REG: begin
                o_cmd.region_rd = 1'b1;
                n_cnt           = cnt_inc;
                if (cnt_inc == sce_pkg::CNT_W'(i_sts.region_num)) begin
                    n_state = S_RDRAIN;
                end
            end
            S_RDRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                // an evaluate result waits until the output register is free
                if (!(r_is_eval && i_sts.out_blocked)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_is_eval <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_is_eval <= n_is_eval;
        end
    end

endmodule

/* hdl/sce_datapath.sv */
// datapath: area stores, configuration, running sums and output register
module sce_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sce_pkg::t_dp_cmd                       i_cmd,
    output sce_pkg::t_dp_sts                       o_sts,
    input  logic                                   i_cfg_valid,
    input  logic [sce_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [sce_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic [sce_pkg::CMD_W-1:0]              i_command,
    input  logic [sce_pkg::INDEX_W-1:0]            i_index,
    input  logic [sce_pkg::AREA_W-1:0]             i_area,
    input  logic [sce_pkg::MASK_W-1:0]             i_owner_mask,
    input  logic [sce_pkg::MASK_W-1:0]             i_sleep_mask,
    input  logic [sce_pkg::MASK_W-1:0]             i_alive_mask,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [sce_pkg::COV_W-1:0]       o_awake_cov,
    output logic signed [sce_pkg::COV_W-1:0]       o_session_cov,
    output logic signed [sce_pkg::COV_W-1:0]       o_solo_area
);

    // configuration registers
    logic [sce_pkg::NODE_CFG_W-1:0] r_node_count;
    logic [sce_pkg::REG_CFG_W-1:0]  r_region_count;

    // node and region stores
    logic [sce_pkg::AREA_BITS-1:0] r_node_mem [sce_pkg::MAX_NODES];
    logic [sce_pkg::MAX_NODES-1:0] r_node_vld;
    logic [sce_pkg::AREA_BITS-1:0] r_reg_area [sce_pkg::MAX_REGIONS];
    logic [sce_pkg::MASK_W-1:0]    r_reg_own  [sce_pkg::MAX_REGIONS];

    // read stage
    logic [sce_pkg::AREA_BITS-1:0] r_node_rd;
    logic                          r_node_take;
    logic [sce_pkg::AREA_BITS-1:0] r_ra_rd;
    logic [sce_pkg::MASK_W-1:0]    r_ro_rd;
    logic                          r_reg_pend;

    // per-item context and sums
    logic                             r_is_eval;
    logic [sce_pkg::MASK_W-1:0]       r_sleep;
    logic [sce_pkg::MASK_W-1:0]       r_alive;
    logic signed [sce_pkg::ACC_W-1:0] r_part;
    logic signed [sce_pkg::ACC_W-1:0] r_excl;
    logic signed [sce_pkg::COV_W-1:0] r_session;

    // output register
    logic                             r_out_vld;
    logic signed [sce_pkg::COV_W-1:0] r_out_part;
    logic signed [sce_pkg::COV_W-1:0] r_out_total;
    logic signed [sce_pkg::COV_W-1:0] r_out_excl;

    logic [sce_pkg::NODE_NUM_W-1:0] node_num;
    logic [sce_pkg::REG_NUM_W-1:0]  region_num;
    logic [sce_pkg::MASK_W-1:0]     inuse;
    logic [sce_pkg::NODE_IDX_W-1:0] node_wr_addr;
    logic [sce_pkg::NODE_IDX_W-1:0] node_rd_addr;
    logic [sce_pkg::REG_IDX_W-1:0]  reg_wr_addr;
    logic [sce_pkg::REG_IDX_W-1:0]  reg_rd_addr;
    logic                           wr_node;
    logic                           wr_region;
    logic                           start;
    logic [sce_pkg::MASK_W-1:0]     sleep_sh;
    logic [sce_pkg::MASK_W-1:0]     alive_sh;
    logic                           node_take;
    logic [sce_pkg::MASK_W-1:0]     own;
    logic [sce_pkg::MASK_W-1:0]     own_live;
    logic [sce_pkg::MASK_W-1:0]     awake_live;
    logic                           one_awake;
    logic signed [sce_pkg::ACC_W-1:0] node_ext;
    logic signed [sce_pkg::ACC_W-1:0] reg_ext;

    // counts in force, limited to the store sizes
    always_comb begin
        if (int'(r_node_count) > sce_pkg::MAX_NODES) begin
            node_num = sce_pkg::NODE_NUM_W'(sce_pkg::MAX_NODES);
        end else begin
            node_num = sce_pkg::NODE_NUM_W'(r_node_count);
        end
        if (int'(r_region_count) > sce_pkg::MAX_REGIONS) begin
            region_num = sce_pkg::REG_NUM_W'(sce_pkg::MAX_REGIONS);
        end else begin
            region_num = sce_pkg::REG_NUM_W'(r_region_count);
        end
    end

    // owner bits of nodes in use
    always_comb begin
        for (int j = 0; j < sce_pkg::MASK_W; j++) begin
            inuse[j] = (j < int'(node_num));
        end
    end

    assign o_sts.node_num    = node_num;
    assign o_sts.region_num  = region_num;
    assign o_sts.out_blocked = r_out_vld && !i_out_ready;

    // load decode
    assign node_wr_addr = sce_pkg::NODE_IDX_W'(i_index);
    assign reg_wr_addr  = sce_pkg::REG_IDX_W'(i_index);
    assign node_rd_addr = i_cmd.addr[sce_pkg::NODE_IDX_W-1:0];
    assign reg_rd_addr  = i_cmd.addr[sce_pkg::REG_IDX_W-1:0];
    assign wr_node   = i_cmd.accept && (i_command == sce_pkg::CMD_LOAD_NODE) &&
                       (int'(i_index) < sce_pkg::MAX_NODES);
    assign wr_region = i_cmd.accept && (i_command == sce_pkg::CMD_LOAD_REGION) &&
                       (int'(i_index) < sce_pkg::MAX_REGIONS);
    assign start     = i_cmd.accept && (i_command == sce_pkg::CMD_INIT ||
                                        i_command == sce_pkg::CMD_EVAL);

    // mask bit of the node being read; nodes past the mask width read as clear
    assign sleep_sh  = r_sleep >> i_cmd.addr;
    assign alive_sh  = r_alive >> i_cmd.addr;
    assign node_take = r_is_eval ? (sleep_sh[0] && alive_sh[0]) : alive_sh[0];

    // region classification on the registered read data
    assign own        = r_ro_rd & inuse;
    assign own_live   = own & r_alive;
    assign awake_live = own_live & ~r_sleep;
    assign one_awake  = (awake_live != '0) &&
                        ((awake_live & (awake_live - 1'b1)) == '0);

    assign node_ext = signed'(sce_pkg::ACC_W'(r_node_rd));
    assign reg_ext  = signed'(sce_pkg::ACC_W'(r_ra_rd));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count   <= sce_pkg::NODE_CFG_W'(32);
            r_region_count <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sce_pkg::REG_NODE_COUNT: begin
                    r_node_count <= i_cfg_data[sce_pkg::NODE_CFG_W-1:0];
                end
                sce_pkg::REG_REGION_COUNT: begin
                    r_region_count <= i_cfg_data[sce_pkg::REG_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // node area store with registered read
    always_ff @(posedge i_clk) begin
        if (wr_node) begin
            r_node_mem[node_wr_addr] <= sce_pkg::AREA_BITS'(i_area);
        end
        if (i_cmd.node_rd) begin
            r_node_rd <= r_node_mem[node_rd_addr];
        end
    end

    // node valid bits: an unwritten node reads as zero area
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_vld  <= '0;
            r_node_take <= 1'b0;
        end else begin
            if (wr_node) begin
                r_node_vld[node_wr_addr] <= 1'b1;
            end
            r_node_take <= i_cmd.node_rd && node_take && r_node_vld[node_rd_addr];
        end
    end

    // region store with registered read
    always_ff @(posedge i_clk) begin
        if (wr_region) begin
            r_reg_area[reg_wr_addr] <= sce_pkg::AREA_BITS'(i_area);
            r_reg_own[reg_wr_addr]  <= i_owner_mask;
        end
        if (i_cmd.region_rd) begin
            r_ra_rd <= r_reg_area[reg_rd_addr];
            r_ro_rd <= r_reg_own[reg_rd_addr];
        end
    end

    // item context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_eval  <= 1'b0;
            r_reg_pend <= 1'b0;
        end else begin
            if (start) begin
                r_is_eval <= (i_command == sce_pkg::CMD_EVAL);
            end
            r_reg_pend <= i_cmd.region_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_sleep <= i_sleep_mask;
            r_alive <= i_alive_mask;
        end
    end

    // running sums
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_part <= (i_command == sce_pkg::CMD_EVAL) ? sce_pkg::ACC_W'(r_session) : '0;
            r_excl <= '0;
        end else if (r_node_take) begin
            r_part <= r_is_eval ? (r_part - node_ext) : (r_part + node_ext);
        end else if (i_cmd.clamp) begin
            if (r_part < 0) begin
                r_part <= '0;
                r_excl <= '0;
            end else begin
                r_excl <= r_part;
            end
        end else if (r_reg_pend) begin
            if (r_is_eval) begin
                if (awake_live == '0 && own_live != '0) begin
                    r_part <= r_part - reg_ext;
                end
                if (one_awake) begin
                    r_excl <= r_excl + reg_ext;
                end
            end else if (own_live != '0) begin
                r_part <= r_part + reg_ext;
            end
        end
    end

    // session total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session <= '0;
        end else if (i_cmd.finish && !r_is_eval) begin
            r_session <= sce_pkg::sat32(r_part);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish && r_is_eval) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_is_eval) begin
            r_out_part  <= sce_pkg::sat32(r_part);
            r_out_total <= r_session;
            r_out_excl  <= sce_pkg::sat32(r_excl);
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_awake_cov   = r_out_part;
    assign o_session_cov = r_out_total;
    assign o_solo_area   = r_out_excl;

endmodule

/* tb/coverage_checker.sv */
// checker for the sensor coverage evaluator: mirrors its stores and compares every result beat
module coverage_checker
    import sce_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [INDEX_W-1:0]      i_index,
    input  logic [AREA_W-1:0]       i_area,
    input  logic [MASK_W-1:0]       i_owner_mask,
    input  logic [MASK_W-1:0]       i_sleep_mask,
    input  logic [MASK_W-1:0]       i_alive_mask,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [COV_W-1:0] i_awake_cov,
    input  logic signed [COV_W-1:0] i_session_cov,
    input  logic signed [COV_W-1:0] i_solo_area,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_mismatches,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COV_MAX = 64'sd2147483647;
    localparam longint COV_MIN = -COV_MAX - 64'sd1;

    // one evaluate result
    typedef struct packed {
        logic signed [COV_W-1:0] partial;
        logic signed [COV_W-1:0] total;
        logic signed [COV_W-1:0] excl;
    } t_cov_beat;

    // mirrored stores and registers
    logic [AREA_W-1:0]     node_area_m    [MAX_NODES];
    logic [AREA_W-1:0]     region_area_m  [MAX_REGIONS];
    logic [MASK_W-1:0]     region_owner_m [MAX_REGIONS];
    longint                session_sum;
    logic [NODE_CFG_W-1:0] node_cnt;
    logic [REG_CFG_W-1:0]  region_cnt;

    t_cov_beat coverage_q [$];
    int        mismatch_n = 0;
    int        pending_n  = 0;

    assign o_mismatches = mismatch_n;
    assign o_pending    = pending_n;

    function automatic longint clip32(input longint v);
        if (v > COV_MAX) return COV_MAX;
        if (v < COV_MIN) return COV_MIN;
        return v;
    endfunction

    function automatic int nodes_in_use();
        return (node_cnt > MAX_NODES) ? MAX_NODES : int'(node_cnt);
    endfunction

    function automatic int regions_in_use();
        return (region_cnt > MAX_REGIONS) ? MAX_REGIONS : int'(region_cnt);
    endfunction

    function automatic logic [MASK_W-1:0] in_use_bits(input int n);
        if (n >= MASK_W) return '1;
        return (MASK_W'(1) << n) - MASK_W'(1);
    endfunction

    // session total for an init beat: live nodes, then regions with a live owner
    function automatic longint session_for(input logic [MASK_W-1:0] alive);
        longint            sum;
        bit                any_live;
        int                n;
        int                r;
        logic [MASK_W-1:0] used;
        n        = nodes_in_use();
        r        = regions_in_use();
        used     = in_use_bits(n);
        sum      = 0;
        any_live = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (i < MASK_W && alive[i]) begin
                sum      += longint'(node_area_m[i]);
                any_live  = 1'b1;
            end
        end
        if (!any_live) sum = 0;
        for (int i = 0; i < r; i++) begin
            if ((region_owner_m[i] & used & alive) != '0) sum += longint'(region_area_m[i]);
        end
        return clip32(sum);
    endfunction

    // result of an evaluate beat
    function automatic t_cov_beat evaluate_for(input logic [MASK_W-1:0] sleep,
                                               input logic [MASK_W-1:0] alive);
        t_cov_beat         res;
        longint            part;
        longint            excl;
        int                n;
        int                r;
        logic [MASK_W-1:0] used;
        logic [MASK_W-1:0] own;
        logic [MASK_W-1:0] awake_live;
        n    = nodes_in_use();
        r    = regions_in_use();
        used = in_use_bits(n);
        part = session_sum;
        // sleeping live nodes give up their exclusive area
        for (int i = 0; i < n; i++) begin
            if (i < MASK_W && sleep[i] && alive[i]) part -= longint'(node_area_m[i]);
        end
        if (part < 0) part = 0;
        excl = part;
        // region walk
        for (int i = 0; i < r; i++) begin
            own        = region_owner_m[i] & used;
            awake_live = own & alive & ~sleep;
            if (awake_live == '0 && (own & alive) != '0) part -= longint'(region_area_m[i]);
            if ($countones(awake_live) == 1) excl += longint'(region_area_m[i]);
        end
        res.partial = COV_W'(clip32(part));
        res.total   = COV_W'(session_sum);
        res.excl    = COV_W'(clip32(excl));
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_n++;
    endtask

    // watch the three channels
    always @(posedge i_clk) begin
        t_cov_beat want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_NODES; i++) node_area_m[i] = '0;
            for (int i = 0; i < MAX_REGIONS; i++) begin
                region_area_m[i]  = '0;
                region_owner_m[i] = '0;
            end
            session_sum = 0;
            node_cnt    = NODE_CFG_W'(32);
            region_cnt  = '0;
            coverage_q.delete();
        end else begin
            // result beat against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (coverage_q.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding");
                end else begin
                    want = coverage_q.pop_front();
                    if (i_awake_cov !== want.partial)
                        report_mismatch($sformatf("awake_cov got %0d expected %0d",
                                                  i_awake_cov, want.partial));
                    if (i_session_cov !== want.total)
                        report_mismatch($sformatf("session_cov got %0d expected %0d",
                                                  i_session_cov, want.total));
                    if (i_solo_area !== want.excl)
                        report_mismatch($sformatf("solo_area got %0d expected %0d",
                                                  i_solo_area, want.excl));
                end
            end
            // register write
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_NODE_COUNT: begin
                        node_cnt = i_cfg_data[NODE_CFG_W-1:0];
                    end
                    REG_REGION_COUNT: begin
                        region_cnt = i_cfg_data[REG_CFG_W-1:0];
                    end
                    default: ;
                endcase
            end
            // command beat
            if (i_in_valid && i_in_ready) begin
                case (i_command)
                    CMD_LOAD_NODE: begin
                        if (i_index < MAX_NODES) node_area_m[i_index] = i_area;
                    end
                    CMD_LOAD_REGION: begin
                        region_area_m[i_index]  = i_area;
                        region_owner_m[i_index] = i_owner_mask;
                    end
                    CMD_INIT: begin
                        session_sum = session_for(i_alive_mask);
                    end
                    CMD_EVAL: begin
                        coverage_q.push_back(evaluate_for(i_sleep_mask, i_alive_mask));
                    end
                    default: ;
                endcase
            end
        end
        pending_n = coverage_q.size();
    end

endmodule

/* tb/testbench.sv */
// top of the sensor coverage evaluator testbench: clock, reset, stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sce_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 128;
    localparam int PHASE_ITEMS   = 110;
    localparam int PHASES        = 12;

    logic                    clk   = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_ready;
    logic [CMD_W-1:0]        command    = CMD_LOAD_NODE;
    logic [INDEX_W-1:0]      index      = '0;
    logic [AREA_W-1:0]       area       = '0;
    logic [MASK_W-1:0]       owner_mask = '0;
    logic [MASK_W-1:0]       sleep_mask = '0;
    logic [MASK_W-1:0]       alive_mask = '0;
    logic                    out_valid;
    logic                    out_ready  = 1'b0;
    logic signed [COV_W-1:0] awake_cov;
    logic signed [COV_W-1:0] session_cov;
    logic signed [COV_W-1:0] solo_area;
    logic                    cfg_valid  = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index  = REG_NODE_COUNT;
    logic [CFG_DATA_W-1:0]   cfg_data   = '0;

    int mismatches;
    int pending;
    int cycle_n   = 0;
    bit calm      = 1'b0;
    int owner_top = 31;

    sensor_coverage_evaluator_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_command      (command),
        .i_index        (index),
        .i_area         (area),
        .i_owner_mask   (owner_mask),
        .i_sleep_mask   (sleep_mask),
        .i_alive_mask   (alive_mask),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_awake_cov    (awake_cov),
        .o_session_cov  (session_cov),
        .o_solo_area    (solo_area),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    coverage_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_command      (command),
        .i_index        (index),
        .i_area         (area),
        .i_owner_mask   (owner_mask),
        .i_sleep_mask   (sleep_mask),
        .i_alive_mask   (alive_mask),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_awake_cov    (awake_cov),
        .i_session_cov  (session_cov),
        .i_solo_area    (solo_area),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // runaway guard
    always @(posedge clk) begin
        cycle_n++;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int draw_hold();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [AREA_W-1:0] pick_area();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            2, 3:    return AREA_W'($urandom_range(0, 1023));
            default: return AREA_W'($urandom());
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom() & $urandom();
            3:       return $urandom() | $urandom();
            4:       return MASK_W'(1) << $urandom_range(0, 31);
            5:       return ~(MASK_W'(1) << $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    // owners are mostly a few nodes among those in use, so single-owner regions show up
    function automatic logic [MASK_W-1:0] pick_owners();
        logic [MASK_W-1:0] m;
        if ($urandom_range(0, 9) < 4) return pick_mask();
        m = '0;
        repeat ($urandom_range(1, 3)) m[$urandom_range(0, owner_top)] = 1'b1;
        return m;
    endfunction

    // one command beat, after a random gap
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                             input logic [AREA_W-1:0] ar, input logic [MASK_W-1:0] own,
                             input logic [MASK_W-1:0] slp, input logic [MASK_W-1:0] alv);
        int gap;
        gap = draw_hold();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command    <= cmd;
        index      <= idx;
        area       <= ar;
        owner_mask <= own;
        sleep_mask <= slp;
        alive_mask <= alv;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_item();
        case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
                send_beat(CMD_LOAD_NODE,
                          INDEX_W'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 63 : 31)),
                          pick_area(), $urandom(), $urandom(), $urandom());
            end
            4, 5, 6, 7: begin
                send_beat(CMD_LOAD_REGION, INDEX_W'($urandom_range(0, 63)), pick_area(),
                          pick_owners(), $urandom(), $urandom());
            end
            8, 9, 10: begin
                send_beat(CMD_INIT, INDEX_W'($urandom()), AREA_W'($urandom()), $urandom(),
                          $urandom(), pick_mask());
            end
            default: begin
                send_beat(CMD_EVAL, INDEX_W'($urandom()), AREA_W'($urandom()), $urandom(),
                          pick_mask(), pick_mask());
            end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, let every result come back and the last walk finish
    task automatic drain();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input int nodes, input int regions);
        drain();
        write_reg(REG_NODE_COUNT, nodes);
        write_reg(REG_REGION_COUNT, regions);
        owner_top = (nodes == 0 || nodes > MASK_W) ? 31 : nodes - 1;
    endtask

    // result side: random stall before each beat
    initial begin
        int hold;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            hold = draw_hold();
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // stimulus
    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // evaluate before any init sees a zero session
        send_beat(CMD_EVAL, '0, '0, '0, '0, '1);
        // node loads at the area extremes, and loads past the node store that are dropped
        send_beat(CMD_LOAD_NODE, 6'd0, '1, '0, '0, '0);
        send_beat(CMD_LOAD_NODE, 6'd31, AREA_W'(1), '0, '0, '0);
        send_beat(CMD_LOAD_NODE, 6'd32, AREA_W'(24'h123456), '0, '0, '0);
        send_beat(CMD_LOAD_NODE, 6'd63, '1, '1, '1, '1);
        // regions with lone, shared and no owners
        send_beat(CMD_LOAD_REGION, 6'd0, '1, MASK_W'(32'h0000_0001), '0, '0);
        send_beat(CMD_LOAD_REGION, 6'd1, AREA_W'(24'h000100), MASK_W'(32'h8000_0000), '0, '0);
        send_beat(CMD_LOAD_REGION, 6'd2, AREA_W'(1), '1, '0, '0);
        send_beat(CMD_LOAD_REGION, 6'd3, AREA_W'(24'h00abcd), '0, '0, '0);
        configure(32, 4);
        send_beat(CMD_INIT, '0, '0, '0, '0, '1);
        send_beat(CMD_EVAL, '0, '0, '0, '0, '1);
        send_beat(CMD_EVAL, '0, '0, '0, '1, '1);
        send_beat(CMD_EVAL, '0, '0, '0, MASK_W'(1), '1);
        send_beat(CMD_EVAL, '0, '0, '0, '1, '0);
        // no node alive
        send_beat(CMD_INIT, '0, '0, '0, '0, '0);
        send_beat(CMD_EVAL, '0, '0, '0, '0, '1);
        // small session, then a sleeping large node drives partial below zero
        send_beat(CMD_INIT, '0, '0, '0, '0, MASK_W'(32'h8000_0000));
        send_beat(CMD_EVAL, '0, '0, '0, MASK_W'(32'h8000_0000), MASK_W'(32'h8000_0000));
        send_beat(CMD_EVAL, '0, '0, '0, MASK_W'(1), MASK_W'(32'h8000_0001));
        send_beat(CMD_INIT, '0, '0, '0, '0, MASK_W'(1));
        send_beat(CMD_EVAL, '0, '0, '0, '0, MASK_W'(1));
        // single node in use: higher owner bits are ignored
        configure(1, 4);
        send_beat(CMD_INIT, '0, '0, '0, '0, '1);
        send_beat(CMD_EVAL, '0, '0, '0, MASK_W'(2), '1);
        // no node in use
        configure(0, 4);
        send_beat(CMD_INIT, '0, '0, '0, '0, '1);
        send_beat(CMD_EVAL, '0, '0, '0, '0, '1);

        // fill the whole region store so any region count reads loaded entries
        configure(32, 4);
        for (int i = 0; i < MAX_REGIONS; i++) begin
            send_beat(CMD_LOAD_REGION, INDEX_W'(i), pick_area(), pick_owners(),
                      $urandom(), $urandom());
        end

        // random phases under different register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       configure(32, 64);
                1:       configure(1, 0);
                2:       configure(0, 64);
                3:       configure(63, 127);
                4:       configure(33, 65);
                5:       configure(32, 1);
                6:       configure($urandom_range(0, 63), $urandom_range(0, 127));
                default: configure($urandom_range(1, 32), $urandom_range(0, 64));
            endcase
            calm = (ph % 4 == 3);
            repeat (PHASE_ITEMS) send_random_item();
        end
        drain();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
